>>> hdl/maze_wall_map_unit_defines.svh
// assertion macros used by the wall map sequencer rtl
`ifndef MAZE_WALL_MAP_UNIT_DEFINES_SVH
`define MAZE_WALL_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wall map: same-cycle check failed");
`define WM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wall map: next-cycle check failed");
`else
`define WM_ASSERT_IMP(label, clk, rst, ante, cons)
`define WM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/maze_wm_pkg.sv
package maze_wm_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int MAX_ROWS_DEF    = 16;

   localparam int MASK_W = 4;
   localparam int SIZE_W = 5;
   localparam int KIND_W = 3;
   localparam int COORD_W = 4;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BOX   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

   // wall bits, rows grow to the north
   localparam logic [MASK_W-1:0] WALL_N = 4'd1;
   localparam logic [MASK_W-1:0] WALL_S = 4'd2;
   localparam logic [MASK_W-1:0] WALL_E = 4'd4;
   localparam logic [MASK_W-1:0] WALL_W = 4'd8;

   typedef struct packed {
      logic              coord_error;
      logic              wall_present;
      logic [MASK_W-1:0] cell_walls;
   } wm_result_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_WIPE,
      ST_BOX,
      ST_BOX_END,
      ST_LOOK,
      ST_RES,
      ST_NB_RD,
      ST_NB_WR
   } fsm_state_type;

endpackage

>>> hdl/maze_wall_map_unit.sv
// channel     | direction | transfer when           | payload
// req         | in        | req_tvalid & req_tready | tuser kind, tdata col/row/wall_mask
// rsp         | out       | rsp_tvalid & rsp_tready | tdata cell_walls/wall_present/coord_error
// csr         | in/out    | psel&penable&pwrite     | maze_width at 0x0, maze_height at 0x4
//
// query or wall change without a neighbour: IDLE then RES; a mirrored change adds NB_RD, NB_WR
// box walks the used rectangle through one read and one write port, then BOX_END, LOOK, RES
// clear grid writes every memory entry once
// after reset the same sweep zeroes the memory while req_tready is low
// one result waits in the output register while the next request is taken; a second waits inside
module maze_wall_map_unit
   import maze_wm_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // col[3:0], row[7:4], wall_mask[11:8], zero fill
   input  logic [2:0]  req_tuser,   // kind[2:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // cell_walls[3:0], wall_present[4], coord_error[5], zero fill
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   // register index decoded from the word address
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic              rsp_valid_ff, rsp_valid_in;
   wm_result_type     rsp_data_ff, rsp_data_in;

   logic              csr_write;
   logic              res_ready;
   logic              res_valid;
   wm_result_type     res;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [MASK_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [MASK_W-1:0] mem_rdata;

   // register port: zero wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_WIDTH:  width_in  = csr_pwdata[SIZE_W-1:0];
            CSR_IDX_HEIGHT: height_in = csr_pwdata[SIZE_W-1:0];
            default:        width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_WIDTH:  csr_prdata = 32'(width_ff);
         CSR_IDX_HEIGHT: csr_prdata = 32'(height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer: decodes the request, drives the memory, holds one result
   maze_wm_ctrl #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .DEPTH       (DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .maze_width  (width_ff),
      .maze_height (height_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser[KIND_W-1:0]),
      .req_col     (req_tdata[3:0]),
      .req_row     (req_tdata[7:4]),
      .req_mask    (req_tdata[11:8]),
      .res_ready   (res_ready),
      .res_valid   (res_valid),
      .res         (res),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   // wall masks, one entry per cell, row-major at MAX_COLUMNS stride
   maze_wm_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register parts the result stream from the sequencer
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = (res_valid && res_ready) ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_W'(MAX_COLUMNS_DEF);
         height_ff    <= SIZE_W'(MAX_ROWS_DEF);
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.coord_error, rsp_data_ff.wall_present,
                        rsp_data_ff.cell_walls};

endmodule

>>> hdl/maze_wm_ram.sv
module maze_wm_ram
   import maze_wm_pkg::*;
#(
   parameter int DEPTH  = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [MASK_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [MASK_W-1:0] rdata
);

   logic [MASK_W-1:0] wall_mem [DEPTH];
   logic [MASK_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         wall_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= wall_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/maze_wm_ctrl.sv
`include "maze_wall_map_unit_defines.svh"

module maze_wm_ctrl
   import maze_wm_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int DEPTH       = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
   parameter int ADDR_W      = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SIZE_W-1:0]  maze_width,
   input  logic [SIZE_W-1:0]  maze_height,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row,
   input  logic [MASK_W-1:0]  req_mask,
   input  logic               res_ready,
   output logic               res_valid,
   output wm_result_type      res,
   output logic               mem_we,
   output logic [ADDR_W-1:0]  mem_waddr,
   output logic [MASK_W-1:0]  mem_wdata,
   output logic               mem_re,
   output logic [ADDR_W-1:0]  mem_raddr,
   input  logic [MASK_W-1:0]  mem_rdata
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int NCOL_W = $clog2(MAX_COLUMNS + 1);
   localparam int NROW_W = $clog2(MAX_ROWS + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
      return ADDR_W'(32'(r) * MAX_COLUMNS + 32'(c));
   endfunction

   fsm_state_type state_ff, state_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              inside_ff, inside_in;
   logic [ADDR_W-1:0] wipe_ff, wipe_in;
   logic [COL_W-1:0]  bx_ff, bx_in;
   logic [ROW_W-1:0]  by_ff, by_in;
   logic              bpend_ff, bpend_in;
   logic [ADDR_W-1:0] bwa_ff, bwa_in;
   logic [MASK_W-1:0] bbits_ff, bbits_in;
   logic [ADDR_W-1:0] nb_addr_ff, nb_addr_in;
   logic [MASK_W-1:0] nb_bits_ff, nb_bits_in;
   wm_result_type     hold_ff, hold_in;
   logic              hold_vld_ff, hold_vld_in;

   logic [NCOL_W-1:0] used_cols;
   logic [NROW_W-1:0] used_rows;
   logic              req_inside;
   logic              req_accept;
   logic              wipe_last;
   logic              box_last_col;
   logic              box_last_row;
   logic [MASK_W-1:0] box_bits;
   logic [ADDR_W-1:0] tgt_addr;
   logic              set_on;
   logic              is_dir;
   logic              nb_ok;
   logic [ADDR_W-1:0] nb_addr;
   logic [MASK_W-1:0] nb_bits;
   logic              wall_change;
   logic [MASK_W-1:0] changed;
   logic [MASK_W-1:0] walls;
   logic              hold_load;
   wm_result_type     hold_data;

   // size in use, saturated into 1..max
   always_comb begin
      if (maze_width == '0) begin
         used_cols = NCOL_W'(1);
      end else if (32'(maze_width) > MAX_COLUMNS) begin
         used_cols = NCOL_W'(MAX_COLUMNS);
      end else begin
         used_cols = NCOL_W'(maze_width);
      end
      if (maze_height == '0) begin
         used_rows = NROW_W'(1);
      end else if (32'(maze_height) > MAX_ROWS) begin
         used_rows = NROW_W'(MAX_ROWS);
      end else begin
         used_rows = NROW_W'(maze_height);
      end
   end

   assign req_inside = (32'(req_col) < 32'(used_cols)) && (32'(req_row) < 32'(used_rows));
   assign req_ready  = (state_ff == ST_IDLE) && (!hold_vld_ff || res_ready);
   assign req_accept = req_valid && req_ready;
   assign wipe_last  = (wipe_ff == LAST_ADDR);

   // perimeter walk
   assign box_last_col = (32'(bx_ff) == 32'(used_cols) - 32'd1);
   assign box_last_row = (32'(by_ff) == 32'(used_rows) - 32'd1);
   assign box_bits = ((by_ff == '0) ? WALL_S : '0) | (box_last_row ? WALL_N : '0)
                   | ((bx_ff == '0) ? WALL_W : '0) | (box_last_col ? WALL_E : '0);

   assign tgt_addr = cell_addr(col_ff, row_ff);
   assign set_on   = (kind_ff == KIND_SET);

   // mirrored neighbour of a single-direction change
   always_comb begin
      is_dir  = 1'b1;
      nb_ok   = 1'b0;
      nb_addr = '0;
      nb_bits = '0;
      case (mask_ff)
         WALL_N: begin
            nb_ok   = (32'(row_ff) + 32'd1 < 32'(used_rows));
            nb_addr = cell_addr(col_ff, row_ff + ROW_W'(1));
            nb_bits = WALL_S;
         end
         WALL_S: begin
            nb_ok   = (row_ff != '0);
            nb_addr = cell_addr(col_ff, row_ff - ROW_W'(1));
            nb_bits = WALL_N;
         end
         WALL_E: begin
            nb_ok   = (32'(col_ff) + 32'd1 < 32'(used_cols));
            nb_addr = cell_addr(col_ff + COL_W'(1), row_ff);
            nb_bits = WALL_W;
         end
         WALL_W: begin
            nb_ok   = (col_ff != '0);
            nb_addr = cell_addr(col_ff - COL_W'(1), row_ff);
            nb_bits = WALL_E;
         end
         default: begin
            is_dir = 1'b0;
         end
      endcase
   end

   assign wall_change = inside_ff && is_dir && ((kind_ff == KIND_SET) || (kind_ff == KIND_CLR));
   assign changed = set_on ? (mem_rdata | mask_ff) : (mem_rdata & ~mask_ff);
   assign walls   = inside_ff ? (wall_change ? changed : mem_rdata) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_CLEAR: state_in = ST_WIPE;
                  KIND_BOX:   state_in = ST_BOX;
                  default:    state_in = ST_RES;
               endcase
            end
         end
         ST_WIPE: begin
            if (wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_BOX: begin
            if (box_last_col && box_last_row) begin
               state_in = ST_BOX_END;
            end
         end
         ST_BOX_END: state_in = ST_LOOK;
         ST_LOOK:    state_in = ST_RES;
         ST_RES: begin
            if (wall_change && nb_ok) begin
               state_in = ST_NB_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NB_RD: state_in = ST_NB_WR;
         ST_NB_WR: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory controls and datapath registers
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      hold_load  = 1'b0;
      hold_data  = '0;
      kind_in    = kind_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      mask_in    = mask_ff;
      inside_in  = inside_ff;
      wipe_in    = wipe_ff;
      bx_in      = bx_ff;
      by_in      = by_ff;
      bpend_in   = bpend_ff;
      bwa_in     = bwa_ff;
      bbits_in   = bbits_ff;
      nb_addr_in = nb_addr_ff;
      nb_bits_in = nb_bits_ff;
      case (state_ff)
         ST_INIT, ST_WIPE: begin
            mem_we    = 1'b1;
            mem_waddr = wipe_ff;
            wipe_in   = wipe_last ? '0 : wipe_ff + ADDR_W'(1);
            if ((state_ff == ST_WIPE) && wipe_last) begin
               hold_load = 1'b1;
            end
         end
         ST_IDLE: begin
            mem_raddr = req_inside ? cell_addr(COL_W'(req_col), ROW_W'(req_row)) : '0;
            mem_re    = req_accept;
            if (req_accept) begin
               kind_in   = req_kind;
               col_in    = COL_W'(req_col);
               row_in    = ROW_W'(req_row);
               mask_in   = req_mask;
               inside_in = req_inside;
               wipe_in   = '0;
               bx_in     = '0;
               by_in     = '0;
               bpend_in  = 1'b0;
            end
         end
         ST_BOX: begin
            // read this cell while writing back the one before
            mem_re    = 1'b1;
            mem_raddr = cell_addr(bx_ff, by_ff);
            mem_we    = bpend_ff;
            mem_waddr = bwa_ff;
            mem_wdata = mem_rdata | bbits_ff;
            bpend_in  = 1'b1;
            bwa_in    = cell_addr(bx_ff, by_ff);
            bbits_in  = box_bits;
            if (box_last_col) begin
               bx_in = '0;
               by_in = by_ff + ROW_W'(1);
            end else begin
               bx_in = bx_ff + COL_W'(1);
            end
         end
         ST_BOX_END: begin
            mem_we    = 1'b1;
            mem_waddr = bwa_ff;
            mem_wdata = mem_rdata | bbits_ff;
         end
         ST_LOOK: begin
            mem_re    = 1'b1;
            mem_raddr = inside_ff ? tgt_addr : '0;
         end
         ST_RES: begin
            hold_load              = 1'b1;
            hold_data.cell_walls   = walls;
            hold_data.wall_present = |(walls & mask_ff);
            hold_data.coord_error  = !inside_ff && (kind_ff != KIND_BOX);
            mem_we                 = wall_change;
            mem_waddr              = tgt_addr;
            mem_wdata              = changed;
            nb_addr_in             = nb_addr;
            nb_bits_in             = nb_bits;
         end
         ST_NB_RD: begin
            mem_re    = 1'b1;
            mem_raddr = nb_addr_ff;
         end
         ST_NB_WR: begin
            mem_we    = 1'b1;
            mem_waddr = nb_addr_ff;
            mem_wdata = set_on ? (mem_rdata | nb_bits_ff) : (mem_rdata & ~nb_bits_ff);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign hold_in     = hold_load ? hold_data : hold_ff;
   assign hold_vld_in = hold_load ? 1'b1 : (res_ready ? 1'b0 : hold_vld_ff);
   assign res_valid   = hold_vld_ff;
   assign res         = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         wipe_ff     <= '0;
         bpend_ff    <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wipe_ff     <= wipe_in;
         bpend_ff    <= bpend_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      mask_ff    <= mask_in;
      inside_ff  <= inside_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      bwa_ff     <= bwa_in;
      bbits_ff   <= bbits_in;
      nb_addr_ff <= nb_addr_in;
      nb_bits_ff <= nb_bits_in;
      hold_ff    <= hold_in;
   end

   `WM_ASSERT_IMP(a_no_rw_same_cell, clock, reset, mem_we && mem_re, mem_waddr != mem_raddr)
   `WM_ASSERT_IMP(a_hold_free, clock, reset, hold_load, !hold_vld_ff || res_ready)
   `WM_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
   `WM_ASSERT_IMP(a_nb_write_after_read, clock, reset, state_ff == ST_NB_WR, $past(state_ff) == ST_NB_RD)

endmodule

>>> sim/maze_wall_map_unit_test.sv
`timescale 1ns / 1ps

module maze_wall_map_unit_test;
   import maze_wm_pkg::*;

   // register map of the csr port
   localparam logic [2:0] REG_WIDTH_ADDR  = 3'd0;
   localparam logic [2:0] REG_HEIGHT_ADDR = 3'd4;

   // kinds past query carry no operation of their own
   localparam logic [KIND_W-1:0] KIND_SPARE = KIND_QUERY + 3'd1;

   localparam int GRID_CELLS    = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
   // a wipe or a box of the full grid plus some margin
   localparam int SETTLE_CYCLES = GRID_CELLS + 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PLAN_STEPS    = 9;
   localparam int RANDOM_CMDS   = 950;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [MASK_W-1:0]  mask;
   } wall_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // col[3:0], row[7:4], wall_mask[11:8], zero fill
   logic [2:0]  req_tuser = '0;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // cell_walls[3:0], wall_present[4], coord_error[5], zero fill
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   maze_wall_map_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // shadow copy of the wall store and the size registers
   logic [MASK_W-1:0] wall_store [GRID_CELLS];
   logic [SIZE_W-1:0] width_reg  = SIZE_W'(16);
   logic [SIZE_W-1:0] height_reg = SIZE_W'(16);

   wall_cmd_type  cmd_backlog [$];   // commands not yet offered
   wm_result_type due_results [$];   // predicted results in order
   wall_cmd_type  cmd_on_bus;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int failures       = 0;
   int cmds_sent      = 0;
   int results_seen   = 0;
   int sweeps_sent    = 0;
   int cycle_count    = 0;

   initial begin
      foreach (wall_store[i]) wall_store[i] = '0;
   end

   // size in use: register saturated into 1..limit
   function automatic int used_size(logic [SIZE_W-1:0] r, int limit);
      if (r == 0) return 1;
      if (r > limit) return limit;
      return int'(r);
   endfunction

   function automatic void mark_wall(int x, int y, logic [MASK_W-1:0] b, bit on);
      if (on) wall_store[y * MAX_COLUMNS_DEF + x] |= b;
      else wall_store[y * MAX_COLUMNS_DEF + x] &= ~b;
   endfunction

   // applies one command to the shadow store and gives the result it must return
   function automatic wm_result_type apply_wall_cmd(wall_cmd_type c);
      int w, h, x, y, i;
      bit in_grid, on;
      wm_result_type r;
      w = used_size(width_reg, MAX_COLUMNS_DEF);
      h = used_size(height_reg, MAX_ROWS_DEF);
      x = int'(c.col);
      y = int'(c.row);
      in_grid = (x < w) && (y < h);
      on = (c.kind == KIND_SET);
      r = '0;
      if (c.kind == KIND_CLEAR) begin
         // wipes cells outside the size in use as well
         foreach (wall_store[k]) wall_store[k] = '0;
      end else if (c.kind == KIND_BOX) begin
         for (i = 0; i < w; i++) begin
            mark_wall(i, 0, WALL_S, 1'b1);
            mark_wall(i, h - 1, WALL_N, 1'b1);
         end
         for (i = 0; i < h; i++) begin
            mark_wall(0, i, WALL_W, 1'b1);
            mark_wall(w - 1, i, WALL_E, 1'b1);
         end
      end else if (!in_grid) begin
         r.coord_error = 1'b1;
      end else if (c.kind == KIND_SET || c.kind == KIND_CLR) begin
         // the shared wall is mirrored only into a neighbour inside the size in use
         case (c.mask)
            WALL_N: begin
               mark_wall(x, y, WALL_N, on);
               if (y + 1 < h) mark_wall(x, y + 1, WALL_S, on);
            end
            WALL_S: begin
               mark_wall(x, y, WALL_S, on);
               if (y > 0) mark_wall(x, y - 1, WALL_N, on);
            end
            WALL_E: begin
               mark_wall(x, y, WALL_E, on);
               if (x + 1 < w) mark_wall(x + 1, y, WALL_W, on);
            end
            WALL_W: begin
               mark_wall(x, y, WALL_W, on);
               if (x > 0) mark_wall(x - 1, y, WALL_E, on);
            end
            default: ;   // not a single direction: left alone
         endcase
      end
      if (in_grid) r.cell_walls = wall_store[y * MAX_COLUMNS_DEF + x];
      r.wall_present = |(r.cell_walls & c.mask);
      return r;
   endfunction

   function automatic void queue_cmd(logic [KIND_W-1:0] kind, int col, int row,
                                     logic [MASK_W-1:0] mask);
      wall_cmd_type c;
      c.kind = kind;
      c.col  = COORD_W'(col);
      c.row  = COORD_W'(row);
      c.mask = mask;
      cmd_backlog.push_back(c);
   endfunction

   // mostly well-formed wall edits and queries inside the size in use, plus noise
   function automatic wall_cmd_type random_wall_cmd();
      logic [MASK_W-1:0] dirs [4];
      int w, h, pick;
      wall_cmd_type c;
      dirs = '{WALL_N, WALL_S, WALL_E, WALL_W};
      w = used_size(width_reg, MAX_COLUMNS_DEF);
      h = used_size(height_reg, MAX_ROWS_DEF);
      pick = $urandom_range(0, 99);
      c.col  = COORD_W'($urandom_range(0, w - 1));
      c.row  = COORD_W'($urandom_range(0, h - 1));
      c.mask = dirs[$urandom_range(0, 3)];
      if (pick < 3) begin
         c.kind = KIND_CLEAR;
      end else if (pick < 7) begin
         c.kind = KIND_BOX;
      end else if (pick < 57) begin
         c.kind = ($urandom_range(0, 2) == 0) ? KIND_CLR : KIND_SET;
      end else if (pick < 80) begin
         c.kind = KIND_QUERY;
         c.mask = MASK_W'($urandom_range(0, 15));
      end else begin
         // noise: any kind, any coordinate, any mask
         c = wall_cmd_type'(15'($urandom_range(0, (1 << $bits(wall_cmd_type)) - 1)));
      end
      return c;
   endfunction

   // one apb write: setup cycle then access cycle
   task automatic write_csr(logic [2:0] addr, logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      // upper bits carry junk that the register must drop
      csr_pwdata  <= {27'($urandom_range(0, 32'h07ff_ffff)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == REG_WIDTH_ADDR) width_reg = value;
      else height_reg = value;
   endtask

   // wait until every command has been taken and answered, then let a sweep finish
   task automatic settle_block();
      while (cmd_backlog.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: offers the oldest pending command, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(apply_wall_cmd(cmd_on_bus));
            cmds_sent++;
            if (cmd_on_bus.kind == KIND_CLEAR || cmd_on_bus.kind == KIND_BOX) sweeps_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cmd_on_bus = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, cmd_on_bus.mask, cmd_on_bus.row, cmd_on_bus.col};
               req_tuser  <= cmd_on_bus.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each transfer against the oldest prediction
   always @(posedge clock) begin
      wm_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = wm_result_type'(rsp_tdata[5:0]);
            results_seen++;
            if (due_results.size() == 0) begin
               $display("%t: result with nothing expected, got %h", $time, got);
               failures++;
            end else begin
               want = due_results.pop_front();
               if (got.cell_walls !== want.cell_walls) begin
                  $display("%t: cell_walls expected %h got %h", $time,
                           want.cell_walls, got.cell_walls);
                  failures++;
               end
               if (got.wall_present !== want.wall_present) begin
                  $display("%t: wall_present expected %b got %b", $time,
                           want.wall_present, got.wall_present);
                  failures++;
               end
               if (got.coord_error !== want.coord_error) begin
                  $display("%t: coord_error expected %b got %b", $time,
                           want.coord_error, got.coord_error);
                  failures++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%t: timed out with %0d results outstanding", $time, due_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // size plan: reset values first, then degenerate, saturating and odd sizes
   logic [SIZE_W-1:0] plan_width  [PLAN_STEPS] = '{16, 1, 0, 5, 31, 17, 9, 2, 16};
   logic [SIZE_W-1:0] plan_height [PLAN_STEPS] = '{16, 1, 31, 7, 0, 3, 16, 2, 16};

   initial begin
      int p, n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < PLAN_STEPS; p++) begin
         // the first settle also covers the wipe after reset
         settle_block();
         if (p > 0) begin
            write_csr(REG_WIDTH_ADDR, plan_width[p]);
            write_csr(REG_HEIGHT_ADDR, plan_height[p]);
         end
         // receiver-heavy stalling, then sender-heavy idling, then none
         @(negedge clock);
         if (p < 3) begin
            send_idle_pct  = 35;
            recv_stall_pct = 61;
         end else if (p < 6) begin
            send_idle_pct  = 61;
            recv_stall_pct = 35;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if (p == 0) begin
            // full 16 by 16 grid: edges, mirroring, odd masks, spare kinds
            queue_cmd(KIND_QUERY, 0, 0, '0);
            queue_cmd(KIND_SET, 0, 0, WALL_N);
            queue_cmd(KIND_SET, 0, 0, WALL_S);
            queue_cmd(KIND_SET, 15, 15, WALL_E);
            queue_cmd(KIND_SET, 0, 5, WALL_W);
            queue_cmd(KIND_SET, 3, 15, WALL_N);
            queue_cmd(KIND_SET, 7, 7, WALL_W);
            queue_cmd(KIND_QUERY, 6, 7, WALL_E);
            queue_cmd(KIND_CLR, 6, 7, WALL_E);
            queue_cmd(KIND_SET, 2, 2, 4'h0);
            queue_cmd(KIND_SET, 2, 2, 4'hf);
            queue_cmd(KIND_CLR, 0, 0, WALL_N | WALL_S);
            queue_cmd(KIND_BOX, 15, 15, 4'hf);
            queue_cmd(KIND_QUERY, 0, 0, 4'hf);
            queue_cmd(KIND_SPARE, 15, 15, WALL_E);
            queue_cmd(KIND_SPARE + 3'd1, 0, 15, WALL_N);
            queue_cmd(KIND_SPARE + 3'd2, 15, 0, WALL_S);
            queue_cmd(KIND_CLEAR, 2, 3, 4'hf);
         end else if (p == 3) begin
            // 5 by 7: bad coordinates, no mirror past the top row, sweeps off the grid
            queue_cmd(KIND_QUERY, 15, 15, 4'hf);
            queue_cmd(KIND_SET, 5, 0, WALL_E);
            queue_cmd(KIND_CLR, 0, 7, WALL_S);
            queue_cmd(KIND_SET, 4, 6, WALL_N);
            queue_cmd(KIND_QUERY, 4, 6, WALL_N);
            queue_cmd(KIND_BOX, 9, 9, 4'hf);
            queue_cmd(KIND_QUERY, 4, 0, WALL_E | WALL_S);
            queue_cmd(KIND_CLEAR, 9, 2, 4'hf);
         end
         n = RANDOM_CMDS / PLAN_STEPS;
         // first half, then a full drain so the sender waits on every result
         repeat (n / 2) cmd_backlog.push_back(random_wall_cmd());
         while (cmd_backlog.size() != 0 || req_tvalid || due_results.size() != 0)
            @(negedge clock);
         repeat (n - n / 2) cmd_backlog.push_back(random_wall_cmd());
      end
      settle_block();
      if (due_results.size() != 0) begin
         $display("%t: %0d results never arrived", $time, due_results.size());
         failures++;
      end
      $display("covered %0d commands (%0d grid sweeps) over %0d size settings", cmds_sent,
               sweeps_sent, PLAN_STEPS);
      $display("checked %0d results, %0d mismatches", results_seen, failures);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
